FILE: rtl/dpw_pkg.sv
// Shared constants, codes and types of the depth pixel to world point unit.
`timescale 1ns / 1ps
package dpw_pkg;

    // Field widths
    localparam int COORD_BITS      = 12;
    localparam int DEPTH_FRAC_BITS = 16;
    localparam int PIXEL_IDX_W     = 12;
    localparam int STEP_W          = 7;
    localparam int DEPTH_W         = 24;
    localparam int FOCAL_W         = 24;
    localparam int CTR_W           = 20;
    localparam int SUBPIX_BITS     = 8;
    localparam int POSE_W          = 32;
    localparam int POSE_IDX_W      = 4;
    localparam int POSE_WORDS      = 12;
    localparam int TRANS_BASE      = 9;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;
    localparam int COORD_OUT_W     = 32;
    localparam int COLOR_W         = 8;

    // Back-projection datapath
    localparam int PIX_W   = COORD_BITS + SUBPIX_BITS;
    localparam int NUM_W   = ((PIX_W > CTR_W) ? PIX_W : CTR_W) + 1;
    localparam int MAG_W   = NUM_W - 1;
    localparam int PROD_W  = MAG_W + DEPTH_W;
    localparam int DIVD_W  = PROD_W + 1;
    localparam int QUOT_W  = 30;
    localparam int SHDIV_W = FOCAL_W + QUOT_W;
    localparam int MOD_W   = COORD_BITS + STEP_W;
    localparam int CAM_W   = 32;

    // Pose datapath
    localparam int WPROD_W  = POSE_W + CAM_W;
    localparam int WSUM_W   = WPROD_W + 2;
    localparam int ROUND_SH = 14 + DEPTH_FRAC_BITS;
    localparam int WQ_W     = WSUM_W + 1 - ROUND_SH;
    localparam int WACC_W   = WQ_W + 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEPTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_SELECT = 3'd7;

    // Register reset values
    localparam logic [STEP_W-1:0]  RST_GRID_STEP   = 7'd4;
    localparam logic [DEPTH_W-1:0] RST_MIN_DEPTH   = 24'd13107;
    localparam logic [DEPTH_W-1:0] RST_MAX_DEPTH   = 24'd1966080;
    localparam logic [FOCAL_W-1:0] RST_FOCAL_X     = 24'd153600;
    localparam logic [FOCAL_W-1:0] RST_FOCAL_Y     = 24'd153600;
    localparam logic [CTR_W-1:0]   RST_CENTER_X    = 20'd81920;
    localparam logic [CTR_W-1:0]   RST_CENTER_Y    = 20'd61440;

    // Camera colours
    localparam logic [COLOR_W-1:0] RED_LEFT    = 8'd30;
    localparam logic [COLOR_W-1:0] GREEN_LEFT  = 8'd60;
    localparam logic [COLOR_W-1:0] BLUE_LEFT   = 8'd255;
    localparam logic [COLOR_W-1:0] RED_RIGHT   = 8'd255;
    localparam logic [COLOR_W-1:0] GREEN_RIGHT = 8'd30;
    localparam logic [COLOR_W-1:0] BLUE_RIGHT  = 8'd30;

    typedef enum logic [1:0] {
        KIND_DROP = 2'd0,
        KIND_PIX  = 2'd1,
        KIND_POSE = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic [POSE_IDX_W-1:0]   pose_idx;
        logic signed [POSE_W-1:0] pose_val;
    } tag_t;

    typedef struct packed {
        logic [STEP_W-1:0]  grid_step;
        logic [DEPTH_W-1:0] min_depth;
        logic [DEPTH_W-1:0] max_depth;
        logic [FOCAL_W-1:0] focal_x;
        logic [FOCAL_W-1:0] focal_y;
        logic [CTR_W-1:0]   center_x;
        logic [CTR_W-1:0]   center_y;
        logic               side_select;
    } cfg_t;

    typedef struct packed {
        tag_t                  tag;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [DEPTH_W-1:0]    z;
        logic                  neg_x;
        logic                  neg_y;
        logic [DIVD_W-1:0]     divd_x;
        logic [DIVD_W-1:0]     divd_y;
    } front_t;

    typedef struct packed {
        tag_t                    tag;
        logic signed [CAM_W-1:0] cam_x;
        logic signed [CAM_W-1:0] cam_y;
        logic [DEPTH_W-1:0]      z;
    } cam_t;

endpackage

FILE: rtl/dpw_if.sv
// Stream channel interfaces: depth pixel input and world point output.
`timescale 1ns / 1ps
interface dpw_pixel_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 func;
    logic [dpw_pkg::PIXEL_IDX_W-1:0]      pixel_col;
    logic [dpw_pkg::PIXEL_IDX_W-1:0]      pixel_row;
    logic [dpw_pkg::DEPTH_W-1:0]          depth_value;
    logic                                 depth_finite;
    logic [dpw_pkg::POSE_IDX_W-1:0]       pose_index;
    logic signed [dpw_pkg::POSE_W-1:0]    pose_value;

    modport source (output valid, func, pixel_col, pixel_row, depth_value, depth_finite,
                    pose_index, pose_value, input ready);
    modport sink   (input valid, func, pixel_col, pixel_row, depth_value, depth_finite,
                    pose_index, pose_value, output ready);
endinterface

interface dpw_point_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [dpw_pkg::COORD_OUT_W-1:0] world_x;
    logic signed [dpw_pkg::COORD_OUT_W-1:0] world_y;
    logic signed [dpw_pkg::COORD_OUT_W-1:0] world_z;
    logic [dpw_pkg::COLOR_W-1:0]            red;
    logic [dpw_pkg::COLOR_W-1:0]            green;
    logic [dpw_pkg::COLOR_W-1:0]            blue;

    modport source (output valid, world_x, world_y, world_z, red, green, blue, input ready);
    modport sink   (input valid, world_x, world_y, world_z, red, green, blue, output ready);
endinterface

FILE: rtl/dpw_front.sv
// Front stages: pixel filter, offset from principal point, depth product, rounding bias.
`timescale 1ns / 1ps
module dpw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dpw_pkg::cfg_t        cfg,
    dpw_pixel_if.sink            pixels,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dpw_pkg::front_t      out_data
);

    logic                               adv;
    logic [dpw_pkg::COORD_BITS-1:0]     col_in;
    logic [dpw_pkg::COORD_BITS-1:0]     row_in;
    logic [dpw_pkg::NUM_W-1:0]          num_x;
    logic [dpw_pkg::NUM_W-1:0]          num_y;
    logic                               keep;
    dpw_pkg::tag_t                      tag_next;

    // Stage 0
    logic                               v0_reg;
    dpw_pkg::tag_t                      tag0_reg;
    logic [dpw_pkg::COORD_BITS-1:0]     col0_reg, row0_reg;
    logic [dpw_pkg::DEPTH_W-1:0]        z0_reg;
    logic                               negx0_reg, negy0_reg;
    logic [dpw_pkg::MAG_W-1:0]          magx0_reg, magy0_reg;
    // Stage 1
    logic                               v1_reg;
    dpw_pkg::tag_t                      tag1_reg;
    logic [dpw_pkg::COORD_BITS-1:0]     col1_reg, row1_reg;
    logic [dpw_pkg::DEPTH_W-1:0]        z1_reg;
    logic                               negx1_reg, negy1_reg;
    logic [dpw_pkg::PROD_W-1:0]         prodx1_reg, prody1_reg;
    // Stage 2
    logic                               v2_reg;
    dpw_pkg::front_t                    out_reg;

    // Advance all stages together unless the last one is held
    assign adv          = !v2_reg || out_ready;
    assign pixels.ready = adv;

    // Classify the item and offset the pixel from the principal point
    always_comb
    begin
        col_in = dpw_pkg::COORD_BITS'(pixels.pixel_col);
        row_in = dpw_pkg::COORD_BITS'(pixels.pixel_row);
        num_x  = (dpw_pkg::NUM_W'(col_in) << dpw_pkg::SUBPIX_BITS)
                 - dpw_pkg::NUM_W'(cfg.center_x);
        num_y  = (dpw_pkg::NUM_W'(row_in) << dpw_pkg::SUBPIX_BITS)
                 - dpw_pkg::NUM_W'(cfg.center_y);
        keep   = pixels.depth_finite
                 && (pixels.depth_value >= cfg.min_depth)
                 && (pixels.depth_value <= cfg.max_depth)
                 && (cfg.focal_x != '0) && (cfg.focal_y != '0);
        tag_next.pose_idx = pixels.pose_index;
        tag_next.pose_val = pixels.pose_value;
        if (pixels.func)
        begin
            tag_next.kind = dpw_pkg::KIND_POSE;
        end
        else if (keep)
        begin
            tag_next.kind = dpw_pkg::KIND_PIX;
        end
        else
        begin
            tag_next.kind = dpw_pkg::KIND_DROP;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= pixels.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag0_reg  <= tag_next;
            col0_reg  <= col_in;
            row0_reg  <= row_in;
            z0_reg    <= pixels.depth_value;
            negx0_reg <= num_x[dpw_pkg::NUM_W-1];
            negy0_reg <= num_y[dpw_pkg::NUM_W-1];
            magx0_reg <= num_x[dpw_pkg::NUM_W-1] ? dpw_pkg::MAG_W'(-num_x)
                                                 : dpw_pkg::MAG_W'(num_x);
            magy0_reg <= num_y[dpw_pkg::NUM_W-1] ? dpw_pkg::MAG_W'(-num_y)
                                                 : dpw_pkg::MAG_W'(num_y);

            tag1_reg   <= tag0_reg;
            col1_reg   <= col0_reg;
            row1_reg   <= row0_reg;
            z1_reg     <= z0_reg;
            negx1_reg  <= negx0_reg;
            negy1_reg  <= negy0_reg;
            prodx1_reg <= dpw_pkg::PROD_W'(magx0_reg) * dpw_pkg::PROD_W'(z0_reg);
            prody1_reg <= dpw_pkg::PROD_W'(magy0_reg) * dpw_pkg::PROD_W'(z0_reg);

            // Add half the divisor so the quotient rounds to nearest
            out_reg.tag    <= tag1_reg;
            out_reg.col    <= col1_reg;
            out_reg.row    <= row1_reg;
            out_reg.z      <= z1_reg;
            out_reg.neg_x  <= negx1_reg;
            out_reg.neg_y  <= negy1_reg;
            out_reg.divd_x <= dpw_pkg::DIVD_W'(prodx1_reg)
                              + dpw_pkg::DIVD_W'(cfg.focal_x >> 1);
            out_reg.divd_y <= dpw_pkg::DIVD_W'(prody1_reg)
                              + dpw_pkg::DIVD_W'(cfg.focal_y >> 1);
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/dpw_div.sv
// Pipelined restoring divider by the focal lengths, with sample step remainder check.
`timescale 1ns / 1ps
module dpw_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dpw_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dpw_pkg::front_t      in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dpw_pkg::cam_t        out_data
);

    typedef struct packed {
        dpw_pkg::tag_t                  tag;
        logic [dpw_pkg::DEPTH_W-1:0]    z;
        logic                           neg_x;
        logic                           neg_y;
        logic                           ovf_x;
        logic                           ovf_y;
        logic [dpw_pkg::DIVD_W-1:0]     rem_x;
        logic [dpw_pkg::DIVD_W-1:0]     rem_y;
        logic [dpw_pkg::QUOT_W-1:0]     quo_x;
        logic [dpw_pkg::QUOT_W-1:0]     quo_y;
        logic [dpw_pkg::COORD_BITS-1:0] rem_col;
        logic [dpw_pkg::COORD_BITS-1:0] rem_row;
    } dstage_t;

    logic                            adv;
    logic [dpw_pkg::STEP_W-1:0]      step_eff;
    logic [dpw_pkg::QUOT_W:0]        v_reg;
    dstage_t                         st_reg  [0:dpw_pkg::QUOT_W];
    dstage_t                         st_next [0:dpw_pkg::QUOT_W];
    logic                            fin_v_reg;
    dpw_pkg::cam_t                   fin_reg;
    dpw_pkg::cam_t                   fin_next;

    assign adv      = !fin_v_reg || out_ready;
    assign in_ready = adv;
    assign step_eff = (cfg.grid_step == '0) ? dpw_pkg::STEP_W'(1) : cfg.grid_step;

    // Overflow check, then one quotient bit per stage; remainder by the step early on
    always_comb
    begin
        logic [dpw_pkg::SHDIV_W-1:0] trial_x;
        logic [dpw_pkg::SHDIV_W-1:0] trial_y;
        logic [dpw_pkg::MOD_W-1:0]   trial_m;
        logic                        take_x;
        logic                        take_y;
        logic [dpw_pkg::QUOT_W-1:0]  qsx;
        logic [dpw_pkg::QUOT_W-1:0]  qsy;

        st_next[0].tag     = in_data.tag;
        st_next[0].z       = in_data.z;
        st_next[0].neg_x   = in_data.neg_x;
        st_next[0].neg_y   = in_data.neg_y;
        st_next[0].ovf_x   = dpw_pkg::SHDIV_W'(in_data.divd_x)
                             >= (dpw_pkg::SHDIV_W'(cfg.focal_x) << dpw_pkg::QUOT_W);
        st_next[0].ovf_y   = dpw_pkg::SHDIV_W'(in_data.divd_y)
                             >= (dpw_pkg::SHDIV_W'(cfg.focal_y) << dpw_pkg::QUOT_W);
        st_next[0].rem_x   = in_data.divd_x;
        st_next[0].rem_y   = in_data.divd_y;
        st_next[0].quo_x   = '0;
        st_next[0].quo_y   = '0;
        st_next[0].rem_col = in_data.col;
        st_next[0].rem_row = in_data.row;

        for (int k = 1; k <= dpw_pkg::QUOT_W; k++)
        begin
            st_next[k] = st_reg[k-1];
            trial_x = dpw_pkg::SHDIV_W'(cfg.focal_x) << (dpw_pkg::QUOT_W - k);
            trial_y = dpw_pkg::SHDIV_W'(cfg.focal_y) << (dpw_pkg::QUOT_W - k);
            take_x  = dpw_pkg::SHDIV_W'(st_reg[k-1].rem_x) >= trial_x;
            take_y  = dpw_pkg::SHDIV_W'(st_reg[k-1].rem_y) >= trial_y;
            if (take_x)
            begin
                st_next[k].rem_x = st_reg[k-1].rem_x - dpw_pkg::DIVD_W'(trial_x);
            end
            if (take_y)
            begin
                st_next[k].rem_y = st_reg[k-1].rem_y - dpw_pkg::DIVD_W'(trial_y);
            end
            st_next[k].quo_x[dpw_pkg::QUOT_W-k] = take_x;
            st_next[k].quo_y[dpw_pkg::QUOT_W-k] = take_y;

            if (k <= dpw_pkg::COORD_BITS)
            begin
                trial_m = dpw_pkg::MOD_W'(step_eff) << (dpw_pkg::COORD_BITS - k);
                if (dpw_pkg::MOD_W'(st_reg[k-1].rem_col) >= trial_m)
                begin
                    st_next[k].rem_col = st_reg[k-1].rem_col
                                         - dpw_pkg::COORD_BITS'(trial_m);
                end
                if (dpw_pkg::MOD_W'(st_reg[k-1].rem_row) >= trial_m)
                begin
                    st_next[k].rem_row = st_reg[k-1].rem_row
                                         - dpw_pkg::COORD_BITS'(trial_m);
                end
            end
        end

        // Saturate, restore the sign, drop pixels off the sampling grid
        qsx = st_reg[dpw_pkg::QUOT_W].ovf_x ? '1 : st_reg[dpw_pkg::QUOT_W].quo_x;
        qsy = st_reg[dpw_pkg::QUOT_W].ovf_y ? '1 : st_reg[dpw_pkg::QUOT_W].quo_y;
        fin_next.tag   = st_reg[dpw_pkg::QUOT_W].tag;
        fin_next.z     = st_reg[dpw_pkg::QUOT_W].z;
        fin_next.cam_x = st_reg[dpw_pkg::QUOT_W].neg_x ? -dpw_pkg::CAM_W'(qsx)
                                                       : dpw_pkg::CAM_W'(qsx);
        fin_next.cam_y = st_reg[dpw_pkg::QUOT_W].neg_y ? -dpw_pkg::CAM_W'(qsy)
                                                       : dpw_pkg::CAM_W'(qsy);
        if ((st_reg[dpw_pkg::QUOT_W].tag.kind == dpw_pkg::KIND_PIX)
            && ((st_reg[dpw_pkg::QUOT_W].rem_col != '0)
                || (st_reg[dpw_pkg::QUOT_W].rem_row != '0)))
        begin
            fin_next.tag.kind = dpw_pkg::KIND_DROP;
        end
    end

    // Valid bits travel with the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            fin_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg     <= {v_reg[dpw_pkg::QUOT_W-1:0], in_valid};
            fin_v_reg <= v_reg[dpw_pkg::QUOT_W];
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= dpw_pkg::QUOT_W; k++)
            begin
                st_reg[k] <= st_next[k];
            end
            fin_reg <= fin_next;
        end
    end

    assign out_valid = fin_v_reg;
    assign out_data  = fin_reg;

endmodule

FILE: rtl/dpw_world.sv
// Pose store and rigid transform stages with rounding, saturation and colour.
`timescale 1ns / 1ps
module dpw_world (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dpw_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  dpw_pkg::cam_t        in_data,
    dpw_point_if.source          points
);

    localparam int NSTG = 5;

    logic                                   adv;
    logic [NSTG-1:0]                        v_reg;
    logic signed [dpw_pkg::POSE_W-1:0]      pose_reg [0:dpw_pkg::POSE_WORDS-1];
    logic signed [dpw_pkg::CAM_W-1:0]       pc       [0:2];

    dpw_pkg::kind_t                         kind0_reg, kind1_reg, kind2_reg, kind3_reg;
    dpw_pkg::kind_t                         kind4_reg;
    logic signed [dpw_pkg::WPROD_W-1:0]     prod0_reg [0:8];
    logic signed [dpw_pkg::POSE_W-1:0]      t0_reg [0:2];
    logic signed [dpw_pkg::POSE_W-1:0]      t1_reg [0:2];
    logic signed [dpw_pkg::POSE_W-1:0]      t2_reg [0:2];
    logic signed [dpw_pkg::POSE_W-1:0]      t3_reg [0:2];
    logic signed [dpw_pkg::WSUM_W-1:0]      sum1_reg [0:2];
    logic                                   neg2_reg [0:2];
    logic                                   neg3_reg [0:2];
    logic [dpw_pkg::WSUM_W-1:0]             mag2_reg [0:2];
    logic [dpw_pkg::WQ_W-1:0]               q3_reg [0:2];
    logic signed [dpw_pkg::COORD_OUT_W-1:0] w4_reg [0:2];
    logic signed [dpw_pkg::COORD_OUT_W-1:0] w_next [0:2];

    // Drain anything that is not a kept pixel without waiting on the sink
    assign adv      = !v_reg[NSTG-1] || points.ready || (kind4_reg != dpw_pkg::KIND_PIX);
    assign in_ready = adv;

    assign pc[0] = in_data.cam_x;
    assign pc[1] = in_data.cam_y;
    assign pc[2] = signed'(dpw_pkg::CAM_W'(in_data.z));

    // Apply the translation and saturate to the output width
    always_comb
    begin
        logic signed [dpw_pkg::WACC_W-1:0] tw;
        logic signed [dpw_pkg::WACC_W-1:0] qv;
        logic signed [dpw_pkg::WACC_W-1:0] acc;
        logic [dpw_pkg::WACC_W-dpw_pkg::COORD_OUT_W:0] top;

        for (int r = 0; r < 3; r++)
        begin
            tw  = dpw_pkg::WACC_W'(t3_reg[r]);
            qv  = signed'(dpw_pkg::WACC_W'(q3_reg[r]));
            acc = neg3_reg[r] ? (tw - qv) : (tw + qv);
            top = acc[dpw_pkg::WACC_W-1:dpw_pkg::COORD_OUT_W-1];
            if ((&top) || !(|top))
            begin
                w_next[r] = acc[dpw_pkg::COORD_OUT_W-1:0];
            end
            else if (acc[dpw_pkg::WACC_W-1])
            begin
                w_next[r] = {1'b1, {(dpw_pkg::COORD_OUT_W-1){1'b0}}};
            end
            else
            begin
                w_next[r] = {1'b0, {(dpw_pkg::COORD_OUT_W-1){1'b1}}};
            end
        end
    end

    // Pose words load in stream order at the stage that reads them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dpw_pkg::POSE_WORDS; i++)
            begin
                pose_reg[i] <= '0;
            end
        end
        else if (adv && in_valid && (in_data.tag.kind == dpw_pkg::KIND_POSE)
                 && (in_data.tag.pose_idx < dpw_pkg::POSE_IDX_W'(dpw_pkg::POSE_WORDS)))
        begin
            pose_reg[in_data.tag.pose_idx] <= in_data.tag.pose_val;
        end
    end

    // Valid bits and kinds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            kind4_reg <= dpw_pkg::KIND_DROP;
        end
        else if (adv)
        begin
            v_reg     <= {v_reg[NSTG-2:0], in_valid};
            kind4_reg <= kind3_reg;
        end
    end

    // Products, sums, magnitude, rounding shift, translation
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind0_reg <= in_data.tag.kind;
            kind1_reg <= kind0_reg;
            kind2_reg <= kind1_reg;
            kind3_reg <= kind2_reg;
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod0_reg[r*3+k] <= pose_reg[r*3+k] * pc[k];
                end
                t0_reg[r]   <= pose_reg[dpw_pkg::TRANS_BASE+r];
                t1_reg[r]   <= t0_reg[r];
                t2_reg[r]   <= t1_reg[r];
                t3_reg[r]   <= t2_reg[r];
                sum1_reg[r] <= dpw_pkg::WSUM_W'(prod0_reg[r*3])
                               + dpw_pkg::WSUM_W'(prod0_reg[r*3+1])
                               + dpw_pkg::WSUM_W'(prod0_reg[r*3+2]);
                neg2_reg[r] <= sum1_reg[r][dpw_pkg::WSUM_W-1];
                mag2_reg[r] <= sum1_reg[r][dpw_pkg::WSUM_W-1]
                               ? dpw_pkg::WSUM_W'(-sum1_reg[r])
                               : dpw_pkg::WSUM_W'(sum1_reg[r]);
                neg3_reg[r] <= neg2_reg[r];
                // Round the magnitude to nearest, ties away from zero
                q3_reg[r]   <= dpw_pkg::WQ_W'(({1'b0, mag2_reg[r]}
                               + ((dpw_pkg::WSUM_W+1)'(1) << (dpw_pkg::ROUND_SH-1)))
                               >> dpw_pkg::ROUND_SH);
                w4_reg[r]   <= w_next[r];
            end
        end
    end

    assign points.valid   = v_reg[NSTG-1] && (kind4_reg == dpw_pkg::KIND_PIX);
    assign points.world_x = w4_reg[0];
    assign points.world_y = w4_reg[1];
    assign points.world_z = w4_reg[2];
    assign points.red     = cfg.side_select ? dpw_pkg::RED_RIGHT   : dpw_pkg::RED_LEFT;
    assign points.green   = cfg.side_select ? dpw_pkg::GREEN_RIGHT : dpw_pkg::GREEN_LEFT;
    assign points.blue    = cfg.side_select ? dpw_pkg::BLUE_RIGHT  : dpw_pkg::BLUE_LEFT;

endmodule

FILE: rtl/depth_pixel_to_world_point_unit.sv
// Top level: configuration registers and the three pipeline sections.
`timescale 1ns / 1ps
// Takes one item per clock while the output is not held and returns one world point for each
// depth pixel that lies on the sampling grid with a finite depth inside the limits; pose word
// loads and rejected pixels give nothing. A point passes 3 front stages, 32 divider stages
// (an overflow check, a 30-stage restoring divide by the focal length, one bit per stage,
// and a sign and saturate stage) and 5 pose stages. Pose words take effect in stream order.
// Write the registers only while the unit is empty.
module depth_pixel_to_world_point_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [dpw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dpw_pkg::CFG_DATA_W-1:0]     cfg_data,
    dpw_pixel_if.sink                          pixels,
    dpw_point_if.source                        points
);

    dpw_pkg::cfg_t      cfg;
    logic [dpw_pkg::STEP_W-1:0]  step_reg;
    logic [dpw_pkg::DEPTH_W-1:0] min_reg, max_reg;
    logic [dpw_pkg::FOCAL_W-1:0] fx_reg, fy_reg;
    logic [dpw_pkg::CTR_W-1:0]   cx_reg, cy_reg;
    logic                        side_reg;

    logic               f_valid, f_ready;
    dpw_pkg::front_t    f_data;
    logic               d_valid, d_ready;
    dpw_pkg::cam_t      d_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= dpw_pkg::RST_GRID_STEP;
            min_reg  <= dpw_pkg::RST_MIN_DEPTH;
            max_reg  <= dpw_pkg::RST_MAX_DEPTH;
            fx_reg   <= dpw_pkg::RST_FOCAL_X;
            fy_reg   <= dpw_pkg::RST_FOCAL_Y;
            cx_reg   <= dpw_pkg::RST_CENTER_X;
            cy_reg   <= dpw_pkg::RST_CENTER_Y;
            side_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dpw_pkg::CFG_GRID_STEP:   step_reg <= dpw_pkg::STEP_W'(cfg_data);
                dpw_pkg::CFG_MIN_DEPTH:   min_reg  <= dpw_pkg::DEPTH_W'(cfg_data);
                dpw_pkg::CFG_MAX_DEPTH:   max_reg  <= dpw_pkg::DEPTH_W'(cfg_data);
                dpw_pkg::CFG_FOCAL_X:     fx_reg   <= dpw_pkg::FOCAL_W'(cfg_data);
                dpw_pkg::CFG_FOCAL_Y:     fy_reg   <= dpw_pkg::FOCAL_W'(cfg_data);
                dpw_pkg::CFG_CENTER_X:    cx_reg   <= dpw_pkg::CTR_W'(cfg_data);
                dpw_pkg::CFG_CENTER_Y:    cy_reg   <= dpw_pkg::CTR_W'(cfg_data);
                dpw_pkg::CFG_SIDE_SELECT: side_reg <= cfg_data[0];
            endcase
        end
    end

    assign cfg.grid_step   = step_reg;
    assign cfg.min_depth   = min_reg;
    assign cfg.max_depth   = max_reg;
    assign cfg.focal_x     = fx_reg;
    assign cfg.focal_y     = fy_reg;
    assign cfg.center_x    = cx_reg;
    assign cfg.center_y    = cy_reg;
    assign cfg.side_select = side_reg;

    dpw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pixels    (pixels),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    dpw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_data  (d_data)
    );

    dpw_world u_world (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (d_valid),
        .in_ready (d_ready),
        .in_data  (d_data),
        .points   (points)
    );

`ifndef NO_ASSERTIONS
    // Input can only stall when a finished point is held at the output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !pixels.ready |-> (points.valid && !points.ready))
        else $error("input stalled without a held output point");

    // Nothing leaves right after reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !points.valid)
        else $error("output valid right after reset");

    // Colour follows the camera side
    a_side_colour: assert property (@(posedge clk) disable iff (!rst_n)
        points.valid |-> (points.red == (side_reg ? dpw_pkg::RED_RIGHT : dpw_pkg::RED_LEFT)))
        else $error("point colour does not match camera side");
`endif

endmodule

FILE: dv/depth_pixel_to_world_point_unit_tb.sv
// Testbench for the depth pixel to world point unit: directed and random streams checked
// against a cycle-free model of the back-projection and pose math.
`timescale 1ns / 1ps
module depth_pixel_to_world_point_unit_tb;

    localparam longint CAM_MAX     = 64'd1073741823;
    localparam int     LATENCY     = 40;
    localparam int     CYCLE_LIMIT = 600000;

    typedef struct {
        logic                              func;
        logic [dpw_pkg::PIXEL_IDX_W-1:0]   col;
        logic [dpw_pkg::PIXEL_IDX_W-1:0]   row;
        logic [dpw_pkg::DEPTH_W-1:0]       depth;
        logic                              finite;
        logic [dpw_pkg::POSE_IDX_W-1:0]    pidx;
        logic signed [dpw_pkg::POSE_W-1:0] pval;
    } pixel_item_t;

    typedef struct {
        logic signed [dpw_pkg::COORD_OUT_W-1:0] wx;
        logic signed [dpw_pkg::COORD_OUT_W-1:0] wy;
        logic signed [dpw_pkg::COORD_OUT_W-1:0] wz;
        logic [dpw_pkg::COLOR_W-1:0]            r;
        logic [dpw_pkg::COLOR_W-1:0]            g;
        logic [dpw_pkg::COLOR_W-1:0]            b;
    } world_point_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [dpw_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [dpw_pkg::CFG_DATA_W-1:0] cfg_data;

    dpw_pixel_if pixels ();
    dpw_point_if points ();

    depth_pixel_to_world_point_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixels),
        .points    (points)
    );

    // Shadow of the register file and the pose words
    dpw_pkg::cfg_t      shadow_cfg;
    logic signed [31:0] pose_words [dpw_pkg::POSE_WORDS];

    world_point_t expected_points [$];
    int  fail_count;
    int  cycle_count;
    int  pixels_sent;
    int  poses_sent;
    int  points_seen;
    int  config_count;
    bit  sender_gaps;
    bit  receiver_stalls;
    bit  hold_request;
    int  hold_left;

    // Clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Camera-frame axis: (pix*256 - ctr) * z / f, rounded and saturated
    function automatic longint cam_axis(longint pix, longint ctr, longint z, longint f);
        longint num;
        longint q;
        bit     neg;
        num = pix * 256 - ctr;
        neg = num < 0;
        q   = ((neg ? -num : num) * z + f / 2) / f;
        if (q > CAM_MAX)
            q = CAM_MAX;
        return neg ? -q : q;
    endfunction

    // One world axis: rotation row times camera point, rounded, plus translation
    function automatic logic signed [31:0] world_axis(int axis, longint cx, longint cy,
                                                      longint cz);
        longint sum;
        longint mag;
        longint w;
        sum = longint'(pose_words[axis*3]) * cx + longint'(pose_words[axis*3+1]) * cy
            + longint'(pose_words[axis*3+2]) * cz;
        mag = sum < 0 ? -sum : sum;
        mag = (mag + (64'sd1 << (dpw_pkg::ROUND_SH - 1))) >>> dpw_pkg::ROUND_SH;
        w   = (sum < 0 ? -mag : mag) + longint'(pose_words[dpw_pkg::TRANS_BASE + axis]);
        if (w > 64'sd2147483647)
            w = 64'sd2147483647;
        if (w < -64'sd2147483648)
            w = -64'sd2147483648;
        return w[31:0];
    endfunction

    // Update the pose store or queue the point that a pixel produces
    function automatic void predict_point(pixel_item_t it);
        longint       step;
        longint       cx;
        longint       cy;
        world_point_t p;
        if (it.func)
        begin
            if (it.pidx < dpw_pkg::POSE_WORDS)
                pose_words[it.pidx] = it.pval;
            return;
        end
        step = shadow_cfg.grid_step == 0 ? 1 : shadow_cfg.grid_step;
        if (!it.finite || it.depth < shadow_cfg.min_depth || it.depth > shadow_cfg.max_depth)
            return;
        if ((it.col % step) != 0 || (it.row % step) != 0)
            return;
        if (shadow_cfg.focal_x == 0 || shadow_cfg.focal_y == 0)
            return;
        cx = cam_axis(it.col, shadow_cfg.center_x, it.depth, shadow_cfg.focal_x);
        cy = cam_axis(it.row, shadow_cfg.center_y, it.depth, shadow_cfg.focal_y);
        p.wx = world_axis(0, cx, cy, it.depth);
        p.wy = world_axis(1, cx, cy, it.depth);
        p.wz = world_axis(2, cx, cy, it.depth);
        if (shadow_cfg.side_select)
        begin
            p.r = dpw_pkg::RED_RIGHT;
            p.g = dpw_pkg::GREEN_RIGHT;
            p.b = dpw_pkg::BLUE_RIGHT;
        end
        else
        begin
            p.r = dpw_pkg::RED_LEFT;
            p.g = dpw_pkg::GREEN_LEFT;
            p.b = dpw_pkg::BLUE_LEFT;
        end
        expected_points.insert(expected_points.size(), p);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one item; called and returns at a rising edge
    task automatic send_item(pixel_item_t it);
        int  gap;
        bit  taken;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            pixels.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixels.valid        <= 1'b1;
        pixels.func         <= it.func;
        pixels.pixel_col    <= it.col;
        pixels.pixel_row    <= it.row;
        pixels.depth_value  <= it.depth;
        pixels.depth_finite <= it.finite;
        pixels.pose_index   <= it.pidx;
        pixels.pose_value   <= it.pval;
        do
        begin
            @(negedge clk);
            taken = pixels.ready;
            @(posedge clk);
        end
        while (!taken);
        predict_point(it);
        if (it.func)
            poses_sent++;
        else
            pixels_sent++;
    endtask

    task automatic go_idle();
        pixels.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every point has arrived and the pipeline has emptied
    task automatic drain();
        go_idle();
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // Write all eight registers; the unit must be empty
    task automatic apply_config(dpw_pkg::cfg_t c);
        logic [dpw_pkg::CFG_DATA_W-1:0] vals [8];
        vals[dpw_pkg::CFG_GRID_STEP]   = dpw_pkg::CFG_DATA_W'(c.grid_step);
        vals[dpw_pkg::CFG_MIN_DEPTH]   = c.min_depth;
        vals[dpw_pkg::CFG_MAX_DEPTH]   = c.max_depth;
        vals[dpw_pkg::CFG_FOCAL_X]     = c.focal_x;
        vals[dpw_pkg::CFG_FOCAL_Y]     = c.focal_y;
        vals[dpw_pkg::CFG_CENTER_X]    = dpw_pkg::CFG_DATA_W'(c.center_x);
        vals[dpw_pkg::CFG_CENTER_Y]    = dpw_pkg::CFG_DATA_W'(c.center_y);
        vals[dpw_pkg::CFG_SIDE_SELECT] = dpw_pkg::CFG_DATA_W'(c.side_select);
        for (int i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= dpw_pkg::CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        @(posedge clk);
        shadow_cfg = c;
        config_count++;
    endtask

    function automatic pixel_item_t pixel_of(int col, int row, int depth, bit finite);
        pixel_item_t it;
        it.func   = 1'b0;
        it.col    = dpw_pkg::PIXEL_IDX_W'(col);
        it.row    = dpw_pkg::PIXEL_IDX_W'(row);
        it.depth  = dpw_pkg::DEPTH_W'(depth);
        it.finite = finite;
        it.pidx   = dpw_pkg::POSE_IDX_W'($urandom);
        it.pval   = $urandom;
        return it;
    endfunction

    function automatic pixel_item_t pose_of(int idx, logic signed [31:0] v);
        pixel_item_t it;
        it        = pixel_of($urandom, $urandom, $urandom, 1'($urandom));
        it.func   = 1'b1;
        it.pidx   = dpw_pkg::POSE_IDX_W'(idx);
        it.pval   = v;
        return it;
    endfunction

    function automatic logic signed [31:0] rand_pose_value(int idx);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
            2: return idx < dpw_pkg::TRANS_BASE ? 32'sh4000_0000 : 32'sh0;
            default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    // Mostly pixels on the grid inside the depth window, the rest noise
    function automatic pixel_item_t rand_item();
        int step;
        int lo;
        int hi;
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            r = $urandom_range(0, 15);
            return pose_of(r, rand_pose_value(r));
        end
        if (r < 25)
            return pixel_of($urandom, $urandom, $urandom, 1'($urandom));
        step = shadow_cfg.grid_step == 0 ? 1 : shadow_cfg.grid_step;
        lo   = shadow_cfg.min_depth;
        hi   = shadow_cfg.max_depth;
        if (lo > hi)
            return pixel_of($urandom_range(0, 4095 / step) * step,
                            $urandom_range(0, 4095 / step) * step, $urandom, 1'b1);
        return pixel_of($urandom_range(0, 4095 / step) * step,
                        $urandom_range(0, 4095 / step) * step,
                        $urandom_range(lo, hi), $urandom_range(0, 19) != 0);
    endfunction

    function automatic dpw_pkg::cfg_t rand_config();
        dpw_pkg::cfg_t c;
        int            lo;
        int            hi;
        c.grid_step   = $urandom_range(0, 8) == 0 ? dpw_pkg::STEP_W'($urandom)
                                                  : dpw_pkg::STEP_W'($urandom_range(1, 8));
        lo = $urandom_range(0, 24'h0F_FFFF);
        hi = $urandom_range(lo, 24'hFF_FFFF);
        c.min_depth   = dpw_pkg::DEPTH_W'(lo);
        c.max_depth   = dpw_pkg::DEPTH_W'(hi);
        c.focal_x     = $urandom_range(0, 3) == 0 ? dpw_pkg::FOCAL_W'($urandom)
                                                  : dpw_pkg::FOCAL_W'($urandom_range(25600, 400000));
        c.focal_y     = $urandom_range(0, 3) == 0 ? dpw_pkg::FOCAL_W'($urandom)
                                                  : dpw_pkg::FOCAL_W'($urandom_range(25600, 400000));
        c.center_x    = dpw_pkg::CTR_W'($urandom);
        c.center_y    = dpw_pkg::CTR_W'($urandom);
        c.side_select = 1'($urandom);
        return c;
    endfunction

    // Output ready: random stalls, or a long counted hold-off on request
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
            points.ready <= 1'b0;
        else
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                points.ready <= 1'b0;
            end
            else if (receiver_stalls)
                points.ready <= ($urandom_range(0, 99) < 70) ||
                                ($urandom_range(0, 99) < 50 && !points.ready);
            else
                points.ready <= 1'b1;
        end
    end

    // Compare each point transfer against the oldest expectation
    always @(negedge clk)
    begin
        world_point_t e;
        if (rst_n && points.valid && points.ready)
        begin
            points_seen++;
            if (expected_points.size() == 0)
            begin
                $error("point transfer with nothing expected");
                fail_count++;
            end
            else
            begin
                e = expected_points.pop_front();
                if (points.world_x !== e.wx)
                begin
                    $error("world_x expected %0d got %0d", e.wx, points.world_x);
                    fail_count++;
                end
                if (points.world_y !== e.wy)
                begin
                    $error("world_y expected %0d got %0d", e.wy, points.world_y);
                    fail_count++;
                end
                if (points.world_z !== e.wz)
                begin
                    $error("world_z expected %0d got %0d", e.wz, points.world_z);
                    fail_count++;
                end
                if (points.red !== e.r)
                begin
                    $error("red expected %0d got %0d", e.r, points.red);
                    fail_count++;
                end
                if (points.green !== e.g)
                begin
                    $error("green expected %0d got %0d", e.g, points.green);
                    fail_count++;
                end
                if (points.blue !== e.b)
                begin
                    $error("blue expected %0d got %0d", e.b, points.blue);
                    fail_count++;
                end
            end
        end
    end

    // Load a pose: identity rotation and the given translation
    task automatic load_identity(logic signed [31:0] tx, logic signed [31:0] ty,
                                 logic signed [31:0] tz);
        for (int i = 0; i < 9; i++)
            send_item(pose_of(i, (i % 4 == 0) ? 32'sh4000_0000 : 32'sh0));
        send_item(pose_of(dpw_pkg::TRANS_BASE, tx));
        send_item(pose_of(dpw_pkg::TRANS_BASE + 1, ty));
        send_item(pose_of(dpw_pkg::TRANS_BASE + 2, tz));
    endtask

    // Reset values of the registers, zero pose, pixels on and off the default grid
    task automatic test_reset_state();
        send_item(pixel_of(0, 0, 65536, 1'b1));
        send_item(pixel_of(320, 240, 65536, 1'b1));
        send_item(pixel_of(321, 240, 65536, 1'b1));
        load_identity(32'sh0001_0000, -32'sh0002_0000, 32'sh0);
        send_item(pixel_of(4092, 4092, 1966080, 1'b1));
        send_item(pixel_of(0, 4092, 13107, 1'b1));
        send_item(pixel_of(8, 8, 13106, 1'b1));
        send_item(pixel_of(8, 8, 1966081, 1'b1));
        send_item(pixel_of(8, 8, 65536, 1'b0));
        drain();
    endtask

    // Field extremes, step of zero, side select, saturation of every stage
    task automatic test_extremes();
        dpw_pkg::cfg_t c;
        c = '{grid_step: 7'd0, min_depth: 24'd0, max_depth: 24'hFF_FFFF, focal_x: 24'd1,
              focal_y: 24'hFF_FFFF, center_x: 20'h0, center_y: 20'hF_FFFF,
              side_select: 1'b1};
        apply_config(c);
        send_item(pixel_of(4095, 4095, 24'hFF_FFFF, 1'b1));
        send_item(pixel_of(0, 0, 0, 1'b1));
        send_item(pixel_of(4095, 0, 24'hFF_FFFF, 1'b1));
        send_item(pose_of(0, 32'sh7FFF_FFFF));
        send_item(pose_of(1, -32'sh8000_0000));
        send_item(pose_of(dpw_pkg::TRANS_BASE, 32'sh7FFF_FFFF));
        send_item(pose_of(dpw_pkg::TRANS_BASE + 1, -32'sh8000_0000));
        send_item(pose_of(12, 32'sh1234_5678));
        send_item(pose_of(15, -32'sh1));
        send_item(pixel_of(4095, 4095, 24'hFF_FFFF, 1'b1));
        send_item(pixel_of(1, 0, 24'hFF_FFFF, 1'b1));
        drain();
    endtask

    // Zero focal lengths drop every pixel; step of 64 keeps the coarse grid
    task automatic test_focal_and_step();
        dpw_pkg::cfg_t c;
        c = '{grid_step: 7'd64, min_depth: 24'd100, max_depth: 24'd100, focal_x: 24'd0,
              focal_y: 24'd153600, center_x: 20'd81920, center_y: 20'd61440,
              side_select: 1'b0};
        apply_config(c);
        send_item(pixel_of(64, 64, 100, 1'b1));
        c.focal_x = 24'd153600;
        c.focal_y = 24'd0;
        drain();
        apply_config(c);
        send_item(pixel_of(64, 64, 100, 1'b1));
        c.focal_y = 24'd153600;
        drain();
        apply_config(c);
        send_item(pixel_of(64, 4032, 100, 1'b1));
        send_item(pixel_of(63, 64, 100, 1'b1));
        send_item(pixel_of(64, 64, 99, 1'b1));
        c.grid_step = 7'h7F;
        drain();
        apply_config(c);
        send_item(pixel_of(127 * 3, 127, 100, 1'b1));
        drain();
    endtask

    // Block the output long enough to fill the unit, then pause until empty
    task automatic test_backpressure();
        receiver_stalls = 1'b0;
        sender_gaps = 1'b0;
        hold_request = 1'b1;
        repeat (150) send_item(rand_item());
        drain();
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // Random phases under several register settings
    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++)
        begin
            apply_config(rand_config());
            sender_gaps = ph != 2;
            receiver_stalls = ph != 3;
            repeat (110) send_item(rand_item());
            drain();
        end
    endtask

    initial
    begin
        fail_count = 0;
        cycle_count = 0;
        pixels_sent = 0;
        poses_sent = 0;
        points_seen = 0;
        config_count = 0;
        hold_request = 1'b0;
        hold_left = 0;
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        shadow_cfg = '{grid_step: dpw_pkg::RST_GRID_STEP, min_depth: dpw_pkg::RST_MIN_DEPTH,
                       max_depth: dpw_pkg::RST_MAX_DEPTH, focal_x: dpw_pkg::RST_FOCAL_X,
                       focal_y: dpw_pkg::RST_FOCAL_Y, center_x: dpw_pkg::RST_CENTER_X,
                       center_y: dpw_pkg::RST_CENTER_Y, side_select: 1'b0};
        for (int i = 0; i < dpw_pkg::POSE_WORDS; i++)
            pose_words[i] = '0;
        rst_n               <= 1'b0;
        cfg_write           <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        pixels.valid        <= 1'b0;
        pixels.func         <= 1'b0;
        pixels.pixel_col    <= '0;
        pixels.pixel_row    <= '0;
        pixels.depth_value  <= '0;
        pixels.depth_finite <= 1'b0;
        pixels.pose_index   <= '0;
        pixels.pose_value   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_state();
        test_extremes();
        test_focal_and_step();
        test_backpressure();
        test_random_phases();

        $display("Covered %0d pixels, %0d pose loads, %0d points over %0d register settings",
                 pixels_sent, poses_sent, points_seen, config_count);
        $display("including a long output hold-off and zero, saturating and edge settings");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/dpw_pkg.sv
rtl/dpw_if.sv
rtl/dpw_front.sv
rtl/dpw_div.sv
rtl/dpw_world.sv
rtl/depth_pixel_to_world_point_unit.sv
dv/depth_pixel_to_world_point_unit_tb.sv
